// File: design/dtlf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtlf_pkg
// Shared types, constants and helpers for the direction tagged log FIFO.
// ----------------------------------------------------------------------------
package dtlf_pkg;

    localparam int DEPTH_LOG2_DEF = 10;
    localparam int CFG_W          = 10;
    localparam int FILL_W         = 10;
    localparam int STORED_W       = 4;
    localparam int POS_W          = 4;

    localparam logic [CFG_W-1:0] MIN_FREE_RST = CFG_W'(10);

    localparam logic OP_CAPTURE = 1'b0;
    localparam logic OP_READ    = 1'b1;

    localparam logic [1:0] DIR_NONE = 2'd2;

    localparam logic [7:0] CHR_CR   = 8'h0D;
    localparam logic [7:0] CHR_LF   = 8'h0A;
    localparam logic [7:0] MRK_B0   = 8'hE2;
    localparam logic [7:0] MRK_B1   = 8'h8D;
    localparam logic [7:0] MRK_RX   = 8'h83;
    localparam logic [7:0] MRK_TX   = 8'h84;

    // Expansion sequence positions: CR LF E2 8D mk | byte | suffix
    localparam logic [POS_W-1:0] POS_FIRST   = 4'd0;
    localparam logic [POS_W-1:0] POS_BYTE    = 4'd5;
    localparam logic [POS_W-1:0] POS_END_CR  = 4'd8;
    localparam logic [POS_W-1:0] POS_END_LF  = 4'd9;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PUSH,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic start_cap;
        logic start_rd;
        logic push;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic cap_pushes;
        logic push_last;
        logic out_free;
    } t_status;

    function automatic logic [7:0] seq_byte(input logic [POS_W-1:0] pos,
                                            input logic [7:0] b,
                                            input logic dir);
        logic [7:0] mk;
        logic       lf;
        mk = dir ? MRK_TX : MRK_RX;
        lf = (b == CHR_LF);
        unique case (pos)
            4'd0:    seq_byte = CHR_CR;
            4'd1:    seq_byte = CHR_LF;
            4'd2:    seq_byte = MRK_B0;
            4'd3:    seq_byte = MRK_B1;
            4'd4:    seq_byte = mk;
            4'd5:    seq_byte = b;
            4'd6:    seq_byte = lf ? CHR_CR : MRK_B0;
            4'd7:    seq_byte = lf ? MRK_B0 : MRK_B1;
            4'd8:    seq_byte = lf ? MRK_B1 : mk;
            4'd9:    seq_byte = mk;
            default: seq_byte = 8'h00;
        endcase
    endfunction

endpackage

// File: design/dtlf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtlf_ctrl
// Request sequencer: accepts one request, steps the push sequence of a
// capture that is not dropped, then hands the result to the output register.
// ----------------------------------------------------------------------------
module dtlf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  logic              i_req_op,
    input  dtlf_pkg::t_status i_status,
    output logic              o_req_ready,
    output dtlf_pkg::t_cmd    o_cmd
);

    dtlf_pkg::t_state r_state;
    dtlf_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dtlf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_req_ready = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            dtlf_pkg::ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    if (i_req_op == dtlf_pkg::OP_READ) begin
                        o_cmd.start_rd = 1'b1;
                        n_state        = dtlf_pkg::ST_DONE;
                    end else begin
                        o_cmd.start_cap = 1'b1;
                        n_state = i_status.cap_pushes ? dtlf_pkg::ST_PUSH : dtlf_pkg::ST_DONE;
                    end
                end
            end
            dtlf_pkg::ST_PUSH: begin
                o_cmd.push = 1'b1;
                if (i_status.push_last) begin
                    n_state = dtlf_pkg::ST_DONE;
                end
            end
            dtlf_pkg::ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = dtlf_pkg::ST_IDLE;
                end
            end
            default: n_state = dtlf_pkg::ST_IDLE;
        endcase
    end

endmodule

// File: design/dtlf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtlf_datapath
// Ring memory, pointers, chunk drop and direction state, expansion
// sequence stepping and the output register.
// ----------------------------------------------------------------------------
module dtlf_datapath #(
    parameter int DEPTH_LOG2 = dtlf_pkg::DEPTH_LOG2_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [dtlf_pkg::CFG_W-1:0]  i_cfg_wdata,
    input  logic                        i_dir,
    input  logic [7:0]                  i_byte,
    input  logic                        i_chunk_start,
    input  dtlf_pkg::t_cmd              i_cmd,
    output dtlf_pkg::t_status           o_status,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [7:0]                  o_read_data,
    output logic                        o_read_valid,
    output logic [dtlf_pkg::FILL_W-1:0] o_fill_level,
    output logic [dtlf_pkg::STORED_W-1:0] o_bytes_stored,
    output logic                        o_chunk_dropped
);

    localparam int DEPTH = 1 << DEPTH_LOG2;
    localparam int CW    = (DEPTH_LOG2 > dtlf_pkg::CFG_W) ? DEPTH_LOG2 : dtlf_pkg::CFG_W;
    localparam logic [DEPTH_LOG2-1:0] PTR_MAX = {DEPTH_LOG2{1'b1}};

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_mem_q;

    logic [DEPTH_LOG2-1:0]         r_wp;
    logic [DEPTH_LOG2-1:0]         r_rp;
    logic [1:0]                    r_last_dir;
    logic                          r_dropping;
    logic [dtlf_pkg::CFG_W-1:0]    r_min_free;

    logic                          r_dir;
    logic [7:0]                    r_byte;
    logic [dtlf_pkg::POS_W-1:0]    r_pos;
    logic [dtlf_pkg::POS_W-1:0]    r_end;
    logic [dtlf_pkg::STORED_W-1:0] r_stored;
    logic                          r_own_dropped;
    logic                          r_rvalid;

    logic                          r_out_valid;
    logic [7:0]                    r_out_rdata;
    logic                          r_out_rvalid;
    logic [dtlf_pkg::FILL_W-1:0]   r_out_fill;
    logic [dtlf_pkg::STORED_W-1:0] r_out_stored;
    logic                          r_out_dropped;

    logic [DEPTH_LOG2-1:0] fill;
    logic [DEPTH_LOG2-1:0] free;
    logic                  can_push;
    logic                  n_dropping;
    logic [7:0]            push_byte;

    assign fill       = r_wp - r_rp;
    assign free       = PTR_MAX - fill;
    assign can_push   = (fill != PTR_MAX);
    assign n_dropping = i_chunk_start ? (CW'(free) < CW'(r_min_free)) : r_dropping;
    assign push_byte  = dtlf_pkg::seq_byte(r_pos, r_byte, r_dir);

    assign o_status.cap_pushes = !n_dropping;
    assign o_status.push_last  = (r_pos == r_end);
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.push && can_push) begin
            r_mem[r_wp] <= push_byte;
        end
        if (i_cmd.start_rd) begin
            r_mem_q <= r_mem[r_rp];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_rp        <= '0;
            r_last_dir  <= dtlf_pkg::DIR_NONE;
            r_dropping  <= 1'b0;
            r_min_free  <= dtlf_pkg::MIN_FREE_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_min_free <= i_cfg_wdata;
            end
            if (i_cmd.start_rd && fill != '0) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_cmd.start_cap) begin
                r_dropping <= n_dropping;
                if (!n_dropping) begin
                    r_last_dir <= {1'b0, i_dir};
                end
            end
            if (i_cmd.push && can_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_rd) begin
            r_rvalid      <= (fill != '0);
            r_stored      <= '0;
            r_own_dropped <= 1'b0;
        end
        if (i_cmd.start_cap) begin
            r_rvalid      <= 1'b0;
            r_stored      <= '0;
            r_own_dropped <= 1'b1;
            r_dir         <= i_dir;
            r_byte        <= i_byte;
            r_pos <= (r_last_dir != {1'b0, i_dir}) ? dtlf_pkg::POS_FIRST : dtlf_pkg::POS_BYTE;
            if (i_byte == dtlf_pkg::CHR_CR) begin
                r_end <= dtlf_pkg::POS_END_CR;
            end else if (i_byte == dtlf_pkg::CHR_LF) begin
                r_end <= dtlf_pkg::POS_END_LF;
            end else begin
                r_end <= dtlf_pkg::POS_BYTE;
            end
        end
        if (i_cmd.push) begin
            r_pos <= r_pos + 1'b1;
            if (can_push) begin
                r_stored <= r_stored + 1'b1;
            end
            if (r_pos == dtlf_pkg::POS_BYTE) begin
                r_own_dropped <= !can_push;
            end
        end
        if (i_cmd.finish) begin
            r_out_rdata   <= r_rvalid ? r_mem_q : 8'h00;
            r_out_rvalid  <= r_rvalid;
            r_out_fill    <= dtlf_pkg::FILL_W'(fill);
            r_out_stored  <= r_stored;
            r_out_dropped <= r_own_dropped;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_read_data     = r_out_rdata;
    assign o_read_valid    = r_out_rvalid;
    assign o_fill_level    = r_out_fill;
    assign o_bytes_stored  = r_out_stored;
    assign o_chunk_dropped = r_out_dropped;

    a_stored_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> r_stored < dtlf_pkg::STORED_W'(10))
        else $error("push count overrun");

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> r_pos <= r_end)
        else $error("push position past sequence end");

    a_empty_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.start_rd && fill == '0) |=> $stable(r_rp))
        else $error("read pointer moved on empty read");

    a_drop_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.start_cap && !o_status.cap_pushes) |=> $stable(r_wp))
        else $error("write pointer moved on dropped capture");

endmodule

// File: design/direction_tagged_log_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// direction_tagged_log_fifo
// Byte ring buffer logging captured traffic with direction markers.
// ----------------------------------------------------------------------------
// Slave channel carries one request: tuser {chunk_start, direction, opcode},
// tdata the data byte. A capture logs the byte; a read drains one byte.
// On a direction change CR LF plus a 3-byte UTF-8 marker go in first; CR is
// followed by the marker, LF by CR and the marker. Bytes that do not fit
// are lost. At chunk start the chunk is dropped if free space is below the
// programmed threshold (i_cfg_we / i_cfg_wdata, reset value 10).
// Master channel returns one result per request.
// Timing: one request at a time. A read or a dropped capture needs no
// pushes; any other capture first pushes every byte of its expansion
// (up to 10, even for bytes that no longer fit) one at a time through
// the single write port of the ring memory. Capacity is
// 2**DEPTH_LOG2 - 1 bytes.
// Reset empties the buffer, clears the direction history and the drop flag.
// A stalled result sits in the output register; the next request is taken
// meanwhile and finishes once that register is free.
// ----------------------------------------------------------------------------
module direction_tagged_log_fifo #(
    parameter int DEPTH_LOG2 = dtlf_pkg::DEPTH_LOG2_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [dtlf_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [7:0]                 s_axis_tdata,  // [7:0] data_byte
    input  logic [2:0]                 s_axis_tuser,  // [0] opcode, [1] direction, [2] chunk_start
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [23:0]                m_axis_tdata,  // [7:0] read_data, [17:8] fill_level,
                                                      // [21:18] bytes_stored, [23:22] zero
    output logic [1:0]                 m_axis_tuser   // [0] read_valid, [1] chunk_dropped
);

    dtlf_pkg::t_cmd    cmd;
    dtlf_pkg::t_status status;

    logic [7:0]                      read_data;
    logic                            read_valid;
    logic [dtlf_pkg::FILL_W-1:0]     fill_level;
    logic [dtlf_pkg::STORED_W-1:0]   bytes_stored;
    logic                            chunk_dropped;

    dtlf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .i_req_op    (s_axis_tuser[0]),
        .i_status    (status),
        .o_req_ready (s_axis_tready),
        .o_cmd       (cmd)
    );

    dtlf_datapath #(
        .DEPTH_LOG2 (DEPTH_LOG2)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_dir           (s_axis_tuser[1]),
        .i_byte          (s_axis_tdata),
        .i_chunk_start   (s_axis_tuser[2]),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_out_ready     (m_axis_tready),
        .o_out_valid     (m_axis_tvalid),
        .o_read_data     (read_data),
        .o_read_valid    (read_valid),
        .o_fill_level    (fill_level),
        .o_bytes_stored  (bytes_stored),
        .o_chunk_dropped (chunk_dropped)
    );

    assign m_axis_tdata = {2'b00, bytes_stored, fill_level, read_data};
    assign m_axis_tuser = {chunk_dropped, read_valid};

endmodule
